### rtl/core/gradient_magnitude_l1_normalize_top_assert.svh
// Assertion macros for the gradient magnitude normalizer.
`ifndef GRADIENT_MAGNITUDE_L1_NORMALIZE_TOP_ASSERT_SVH
`define GRADIENT_MAGNITUDE_L1_NORMALIZE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GMLN_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("gmln assertion failed");
`define GMLN_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("gmln assertion failed");
`else
`define GMLN_ASSERT_IMP(label, clk, rst_n, a, b)
`define GMLN_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

### rtl/core/gmln_pkg.sv
// Shared types, widths and helpers for the gradient magnitude normalizer.
`timescale 1ns / 1ps
package gmln_pkg;

    localparam int MAX_PIXELS_DEF = 65536;

    localparam int GRAD_W = 16;
    localparam int MAG_W  = 17;
    localparam int PIX_W  = 8;
    localparam int IDX_W  = 16;
    // mag * 255 never exceeds 24 bits
    localparam int NUM_W  = MAG_W + PIX_W - 1;
    localparam int STEP_W = $clog2(PIX_W);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [PIX_W-1:0] PIX_SCALE = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV
    } gmln_state_t;

    function automatic logic [MAG_W-1:0] abs_grad(input logic [GRAD_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {v[GRAD_W-1], v};
        return v[GRAD_W-1] ? (MAG_W'(0) - ext) : ext;
    endfunction

endpackage

### rtl/core/gmln_div.sv
// Restoring divider: floor(mag * 255 / peak), one quotient bit per cycle.
`timescale 1ns / 1ps
module gmln_div
    import gmln_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] mag,
    input  logic [MAG_W-1:0] peak,
    output logic             done,
    output logic [PIX_W-1:0] quotient
);

    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  num_next;
    logic [NUM_W-1:0]  den_reg;
    logic [PIX_W-1:0]  quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic              run_reg;
    logic              done_reg;
    logic [MAG_W-1:0]  peak_eff;
    logic              fits;

    // a zero peak divides as one
    assign peak_eff = (peak == '0) ? MAG_W'(1) : peak;
    assign fits     = (num_reg >= den_reg);
    assign num_next = fits ? (num_reg - den_reg) : num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(PIX_W - 1);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // mag never exceeds peak, so the quotient fits in PIX_W bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= NUM_W'(mag) * NUM_W'(PIX_SCALE);
            den_reg  <= NUM_W'({peak_eff, {(PIX_W - 1){1'b0}}});
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg  <= num_next;
            den_reg  <= den_reg >> 1;
            quot_reg <= {quot_reg[PIX_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### rtl/core/gradient_magnitude_l1_normalize_top.sv
// Load: one load word per cycle while busy is low; busy stays low.
// Fetch: result strobe after the store read, 8 divide steps and the output register;
// busy is high from the accept until the strobe, while the bit-serial peak divider runs.
// A fetch with nothing to return gives no strobe and leaves busy low.
// Reset clears count, peak, read position and frame flag; store contents stay undefined.
`timescale 1ns / 1ps
`include "gradient_magnitude_l1_normalize_top_assert.svh"
module gradient_magnitude_l1_normalize_top
    import gmln_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              op,
    input  logic [GRAD_W-1:0] grad_x,
    input  logic [GRAD_W-1:0] grad_y,
    input  logic              frame_end,
    output logic              result_valid,
    output logic [PIX_W-1:0]  pixel,
    output logic [IDX_W-1:0]  pixel_index,
    output logic              frame_last
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIXELS);

    logic [MAG_W-1:0] store_mem [0:MAX_PIXELS-1];
    logic [MAG_W-1:0] rd_data_reg;

    gmln_state_t      state_reg;
    gmln_state_t      state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    rpos_reg;
    logic [CW-1:0]    rpos_next;
    logic [MAG_W-1:0] peak_reg;
    logic [MAG_W-1:0] peak_next;
    logic             complete_reg;
    logic             complete_next;

    logic             valid_reg;
    logic [PIX_W-1:0] pixel_reg;
    logic [IDX_W-1:0] index_reg;
    logic             last_reg;

    logic             accept;
    logic             load_acc;
    logic             fetch_ok;
    logic [CW-1:0]    count_eff;
    logic [MAG_W-1:0] peak_eff;
    logic [MAG_W-1:0] mag;
    logic             mem_we;
    logic             div_start;
    logic             div_done;
    logic [PIX_W-1:0] div_quot;

    assign accept    = start && !busy;
    assign load_acc  = accept && (op == OP_LOAD);
    assign fetch_ok  = accept && (op == OP_FETCH) && complete_reg && (rpos_reg < count_reg);
    // a load after a finished frame starts a new one
    assign count_eff = complete_reg ? '0 : count_reg;
    assign peak_eff  = complete_reg ? '0 : peak_reg;
    assign mag       = MAG_W'(abs_grad(grad_x) + abs_grad(grad_y));
    assign mem_we    = load_acc && (count_eff < MAX_CNT);

    always_comb
    begin
        count_next    = count_reg;
        peak_next     = peak_reg;
        rpos_next     = rpos_reg;
        complete_next = complete_reg;
        if (load_acc)
        begin
            count_next = count_eff;
            peak_next  = peak_eff;
            if (complete_reg)
            begin
                rpos_next = '0;
            end
            if (mem_we)
            begin
                count_next = count_eff + 1'b1;
                if (mag > peak_eff)
                begin
                    peak_next = mag;
                end
            end
            complete_next = frame_end ? 1'b1 : 1'b0;
        end
        else if (fetch_ok)
        begin
            rpos_next = rpos_reg + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fetch_ok)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy      = 1'b1;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_READ:
            begin
                div_start = 1'b1;
            end
            ST_DIV:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rpos_reg     <= '0;
            peak_reg     <= '0;
            complete_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rpos_reg     <= rpos_next;
            peak_reg     <= peak_next;
            complete_reg <= complete_next;
            valid_reg    <= (state_reg == ST_DIV) && div_done;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[count_eff[AW-1:0]] <= mag;
        end
        if (fetch_ok)
        begin
            rd_data_reg <= store_mem[rpos_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fetch_ok)
        begin
            index_reg <= IDX_W'(rpos_reg);
            last_reg  <= ((rpos_reg + 1'b1) == count_reg);
        end
        if ((state_reg == ST_DIV) && div_done)
        begin
            pixel_reg <= div_quot;
        end
    end

    gmln_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mag      (rd_data_reg),
        .peak     (peak_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign result_valid = valid_reg;
    assign pixel        = pixel_reg;
    assign pixel_index  = index_reg;
    assign frame_last   = last_reg;

    `GMLN_ASSERT_NXT(a_strobe_single, clk, rst_n, valid_reg, !valid_reg)
    `GMLN_ASSERT_NXT(a_fetch_goes_busy, clk, rst_n, fetch_ok, busy)
    `GMLN_ASSERT_IMP(a_write_only_idle, clk, rst_n, mem_we, state_reg == ST_IDLE)
    `GMLN_ASSERT_IMP(a_div_done_in_div, clk, rst_n, div_done, state_reg == ST_DIV)

endmodule
